// ----- sv/qau_pkg.sv -----
// ----------------------------------------------------------------------------
// qau_pkg
// Operation codes, error codes and transaction payload types of the
// quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam logic [3:0] OP_ADD    = 4'd0;
  localparam logic [3:0] OP_SUB    = 4'd1;
  localparam logic [3:0] OP_MUL    = 4'd2;
  localparam logic [3:0] OP_PURE   = 4'd3;
  localparam logic [3:0] OP_CONJ   = 4'd4;
  localparam logic [3:0] OP_SCALE  = 4'd5;
  localparam logic [3:0] OP_NORMSQ = 4'd6;
  localparam logic [3:0] OP_NORM   = 4'd7;
  localparam logic [3:0] OP_RECIP  = 4'd8;
  localparam logic [3:0] OP_PURITY = 4'd9;

  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_OVF  = 2'd1;
  localparam logic [1:0] ERR_DIV0 = 2'd2;

  localparam logic [2:0] ADDR_ZERO_TOL = 3'd0;
  localparam logic [30:0] ZERO_TOL_RESET = 31'd66;

  typedef struct packed {
    logic [3:0]         operation;
    logic signed [31:0] a_w;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scale_factor;
  } qau_in_t;

  typedef struct packed {
    logic signed [31:0] r_w;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic               scalar_nonzero;
    logic [1:0]         error_code;
  } qau_out_t;

endpackage

// ----- sv/quaternion_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Pipelined signed fixed-point quaternion ALU with an APB register port.
// ----------------------------------------------------------------------------
// Accepts one transaction per clock (busy stays low) and returns each result
// with a one-cycle result_valid strobe. The pipeline depth is set by the
// reciprocal divider: a restoring divider with one quotient bit per stage over
// 32+FRAC_BITS stages; the square root for the norm runs one root bit per
// stage alongside. Every operation takes the same path length, so results
// leave in order.
module quaternion_arithmetic_unit
  import qau_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  qau_in_t     operands,
  output logic        result_valid,
  output qau_out_t    result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int QW = 32 + FRAC_BITS;
  localparam int NW = 64 - FRAC_BITS;
  localparam int D  = QW;

  logic [30:0] zero_tol;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_ZERO_TOL) ? {1'b0, zero_tol} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_tol <= ZERO_TOL_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_ZERO_TOL) begin
      zero_tol <= pwdata[30:0];
    end
  end

  // stage 1
  logic    v1;
  qau_in_t in_q;
  logic signed [31:0] a1 [4];
  logic signed [31:0] b1 [4];
  logic [32:0] mag1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start;
    in_q <= operands;
  end

  assign a1[0] = in_q.a_w;
  assign a1[1] = in_q.a_x;
  assign a1[2] = in_q.a_y;
  assign a1[3] = in_q.a_z;
  assign b1[0] = in_q.b_w;
  assign b1[1] = in_q.b_x;
  assign b1[2] = in_q.b_y;
  assign b1[3] = in_q.b_z;
  assign mag1 = a1[0][31] ? 33'(-33'(a1[0])) : 33'(a1[0]);

  // stage 2
  logic v2;
  logic [3:0] op2;
  logic pur2;
  logic signed [31:0] a2 [4];
  logic signed [31:0] b2 [4];
  logic signed [63:0] pab [4][4];
  logic signed [63:0] psc [4];
  logic signed [63:0] psq [4];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    op2  <= in_q.operation;
    pur2 <= (in_q.operation == OP_PURITY) && (mag1 > {2'b00, zero_tol});
    for (int i = 0; i < 4; i++) begin
      a2[i]  <= a1[i];
      b2[i]  <= b1[i];
      psc[i] <= a1[i] * in_q.scale_factor;
      psq[i] <= a1[i] * a1[i];
      for (int j = 0; j < 4; j++) begin
        pab[i][j] <= a1[i] * b1[j];
      end
    end
  end

  // stage 3
  logic signed [65:0] t [4][4];
  logic signed [65:0] ts [4];
  logic [64:0] sq_exact;
  logic [63:0] sum2;
  logic signed [65:0] rp2 [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ts[i] = 66'(psc[i] >>> FRAC_BITS);
      for (int j = 0; j < 4; j++) begin
        t[i][j] = 66'(pab[i][j] >>> FRAC_BITS);
      end
    end
    sq_exact = 65'($unsigned(psq[0])) + 65'($unsigned(psq[1]))
             + 65'($unsigned(psq[2])) + 65'($unsigned(psq[3]));
    sum2 = sq_exact[64] ? '1 : sq_exact[63:0];
    for (int i = 0; i < 4; i++) rp2[i] = '0;
    case (op2)
      OP_ADD: begin
        for (int i = 0; i < 4; i++) rp2[i] = 66'(a2[i]) + 66'(b2[i]);
      end
      OP_SUB: begin
        for (int i = 0; i < 4; i++) rp2[i] = 66'(a2[i]) - 66'(b2[i]);
      end
      OP_MUL: begin
        rp2[0] = t[0][0] - t[1][1] - t[2][2] - t[3][3];
        rp2[1] = t[1][0] + t[0][1] - t[3][2] + t[2][3];
        rp2[2] = t[2][0] + t[3][1] + t[0][2] - t[1][3];
        rp2[3] = t[3][0] - t[2][1] + t[1][2] + t[0][3];
      end
      OP_PURE: begin
        rp2[1] = t[0][1] + t[1][0] + t[2][3] - t[3][2];
        rp2[2] = t[0][2] + t[2][0] + t[3][1] - t[1][3];
        rp2[3] = t[0][3] + t[3][0] + t[1][2] - t[2][1];
      end
      OP_CONJ: begin
        rp2[0] = 66'(a2[0]);
        for (int i = 1; i < 4; i++) rp2[i] = -66'(a2[i]);
      end
      OP_SCALE: begin
        for (int i = 0; i < 4; i++) rp2[i] = ts[i];
      end
      OP_NORMSQ: begin
        rp2[0] = 66'({2'b00, sum2} >> FRAC_BITS);
      end
      default: begin
        for (int i = 0; i < 4; i++) rp2[i] = '0;
      end
    endcase
  end

  logic v3;
  logic [3:0] op3;
  logic pur3;
  logic [63:0] sum3;
  logic signed [31:0] a3 [4];
  logic signed [65:0] rp3 [4];

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    op3  <= op2;
    pur3 <= pur2;
    sum3 <= sum2;
    for (int i = 0; i < 4; i++) begin
      a3[i]  <= a2[i];
      rp3[i] <= rp2[i];
    end
  end

  // stage 4: saturate direct results, set up root and divider
  qau_out_t fast3;
  logic [31:0] fr [4];
  logic ovf3;
  logic signed [32:0] c3 [4];
  logic [QW-1:0] num3 [4];

  always_comb begin
    ovf3 = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (rp3[i] > 66'sh7FFFFFFF) begin
        fr[i] = 32'h7FFFFFFF;
        ovf3  = 1'b1;
      end else if (rp3[i] < -66'sh80000000) begin
        fr[i] = 32'h80000000;
        ovf3  = 1'b1;
      end else begin
        fr[i] = rp3[i][31:0];
      end
      c3[i] = (i == 0) ? 33'(a3[i]) : -33'(a3[i]);
      num3[i] = QW'(c3[i][32] ? 33'(-c3[i]) : 33'(c3[i])) << FRAC_BITS;
    end
    fast3.r_w = fr[0];
    fast3.r_x = fr[1];
    fast3.r_y = fr[2];
    fast3.r_z = fr[3];
    fast3.scalar_nonzero = pur3;
    fast3.error_code = ovf3 ? ERR_OVF : ERR_OK;
  end

  logic          cv    [0:D];
  logic [3:0]    cop   [0:D];
  qau_out_t      cfast [0:D];
  logic [NW-1:0] cns   [0:D];
  logic          czero [0:D];
  logic          cneg  [0:D][4];
  logic [NW-1:0] drem  [0:D][4];
  logic [QW-1:0] dn    [0:D][4];
  logic [63:0]   sx    [0:D];
  logic [33:0]   srem  [0:D];
  logic [31:0]   sroot [0:D];

  always_ff @(posedge clk) begin
    if (rst) cv[0] <= 1'b0;
    else cv[0] <= v3;
    cop[0]   <= op3;
    cfast[0] <= fast3;
    cns[0]   <= sum3[63:FRAC_BITS];
    czero[0] <= (sum3[63:FRAC_BITS] == '0);
    sx[0]    <= sum3;
    srem[0]  <= '0;
    sroot[0] <= '0;
    for (int i = 0; i < 4; i++) begin
      cneg[0][i] <= c3[i][32];
      drem[0][i] <= '0;
      dn[0][i]   <= num3[i];
    end
  end

  for (genvar k = 0; k < D; k++) begin : g_iter
    logic [NW:0]   dsh [4];
    logic          dge [4];
    logic [35:0]   ssh;
    logic [35:0]   strial;
    logic          sge;

    always_comb begin
      for (int i = 0; i < 4; i++) begin
        dsh[i] = {drem[k][i], dn[k][i][QW-1]};
        dge[i] = dsh[i] >= {1'b0, cns[k]};
      end
      ssh    = {srem[k], sx[k][63:62]};
      strial = {2'b00, sroot[k], 2'b01};
      sge    = ssh >= strial;
    end

    always_ff @(posedge clk) begin
      if (rst) cv[k+1] <= 1'b0;
      else cv[k+1] <= cv[k];
      cop[k+1]   <= cop[k];
      cfast[k+1] <= cfast[k];
      cns[k+1]   <= cns[k];
      czero[k+1] <= czero[k];
      for (int i = 0; i < 4; i++) begin
        cneg[k+1][i] <= cneg[k][i];
        drem[k+1][i] <= dge[i] ? NW'(dsh[i] - {1'b0, cns[k]}) : NW'(dsh[i]);
        dn[k+1][i]   <= {dn[k][i][QW-2:0], dge[i]};
      end
      if (k < 32) begin
        sx[k+1]    <= {sx[k][61:0], 2'b00};
        srem[k+1]  <= sge ? 34'(ssh - strial) : 34'(ssh);
        sroot[k+1] <= {sroot[k][30:0], sge};
      end else begin
        sx[k+1]    <= sx[k];
        srem[k+1]  <= srem[k];
        sroot[k+1] <= sroot[k];
      end
    end
  end

  // output stage
  qau_out_t fin;
  logic [31:0] qr [4];
  logic qovf;

  always_comb begin
    qovf = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!cneg[D][i] && dn[D][i] > QW'(32'h7FFFFFFF)) begin
        qr[i] = 32'h7FFFFFFF;
        qovf  = 1'b1;
      end else if (cneg[D][i] && dn[D][i] > QW'(32'h80000000)) begin
        qr[i] = 32'h80000000;
        qovf  = 1'b1;
      end else begin
        qr[i] = cneg[D][i] ? 32'(-dn[D][i]) : dn[D][i][31:0];
      end
    end
    fin = cfast[D];
    case (cop[D])
      OP_NORM: begin
        fin = '0;
        fin.r_w = sroot[D][31] ? 32'h7FFFFFFF : sroot[D];
        fin.error_code = sroot[D][31] ? ERR_OVF : ERR_OK;
      end
      OP_RECIP: begin
        fin = '0;
        if (czero[D]) begin
          fin.error_code = ERR_DIV0;
        end else begin
          fin.r_w = qr[0];
          fin.r_x = qr[1];
          fin.r_y = qr[2];
          fin.r_z = qr[3];
          fin.error_code = qovf ? ERR_OVF : ERR_OK;
        end
      end
      default: begin
        fin = cfast[D];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else result_valid <= cv[D];
    result <= fin;
  end

endmodule

// ----- sim/quaternion_arithmetic_unit_tb.sv -----
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit_tb
// Self-checking bench for the quaternion arithmetic unit: a directed table of
// corner cases, then random quaternion pairs under several tolerance settings,
// each result compared field by field to a table value or an in-bench model.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit_tb
  import qau_pkg::*;
;

  localparam int  FRAC   = 16;
  localparam int  DRAIN  = 80;
  localparam int  LIMIT  = 300000;
  localparam logic [31:0] QMIN = 32'h8000_0000;
  localparam logic [31:0] QMAX = 32'h7fff_ffff;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  qau_in_t     operands;
  logic        result_valid;
  qau_out_t    result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [30:0] tolerance;
  qau_out_t    pending_q[$];
  int          mismatches;
  int          cycles;

  qau_in_t     dir_in[$];
  bit          dir_typed[$];
  qau_out_t    dir_exp[$];

  quaternion_arithmetic_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operands(operands),
    .result_valid(result_valid), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint qmul(longint x, longint y);
    return (x * y) >>> FRAC;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] rb;
    res = '0;
    rb = 64'd1 << 62;
    while (rb > v) rb = rb >> 2;
    while (rb != 0) begin
      if (v >= res + rb) begin
        v = v - (res + rb);
        res = (res >> 1) + rb;
      end else begin
        res = res >> 1;
      end
      rb = rb >> 2;
    end
    return res;
  endfunction

  function automatic qau_out_t quat_result(qau_in_t q, logic [30:0] tol);
    longint      a[4];
    longint      b[4];
    longint      r[4];
    longint      s;
    longint      ns;
    longint      mag;
    logic [65:0] sq;
    logic [63:0] sumsq;
    logic        ovf;
    logic        div0;
    qau_out_t    o;
    a[0] = q.a_w; a[1] = q.a_x; a[2] = q.a_y; a[3] = q.a_z;
    b[0] = q.b_w; b[1] = q.b_x; b[2] = q.b_y; b[3] = q.b_z;
    s = q.scale_factor;
    r = '{0, 0, 0, 0};
    ovf = 1'b0;
    div0 = 1'b0;
    o = '0;
    sq = '0;
    for (int i = 0; i < 4; i++) sq = sq + 66'(a[i] * a[i]);
    sumsq = (sq > 66'h0_ffff_ffff_ffff_ffff) ? '1 : sq[63:0];
    case (q.operation)
      OP_ADD:  for (int i = 0; i < 4; i++) r[i] = a[i] + b[i];
      OP_SUB:  for (int i = 0; i < 4; i++) r[i] = a[i] - b[i];
      OP_MUL: begin
        r[0] = qmul(a[0], b[0]) - qmul(a[1], b[1]) - qmul(a[2], b[2]) - qmul(a[3], b[3]);
        r[1] = qmul(a[1], b[0]) + qmul(a[0], b[1]) - qmul(a[3], b[2]) + qmul(a[2], b[3]);
        r[2] = qmul(a[2], b[0]) + qmul(a[3], b[1]) + qmul(a[0], b[2]) - qmul(a[1], b[3]);
        r[3] = qmul(a[3], b[0]) - qmul(a[2], b[1]) + qmul(a[1], b[2]) + qmul(a[0], b[3]);
      end
      OP_PURE: begin
        r[1] = qmul(a[0], b[1]) + qmul(b[0], a[1]) + qmul(a[2], b[3]) - qmul(a[3], b[2]);
        r[2] = qmul(a[0], b[2]) + qmul(b[0], a[2]) + qmul(a[3], b[1]) - qmul(a[1], b[3]);
        r[3] = qmul(a[0], b[3]) + qmul(b[0], a[3]) + qmul(a[1], b[2]) - qmul(a[2], b[1]);
      end
      OP_CONJ: begin
        r[0] = a[0];
        for (int i = 1; i < 4; i++) r[i] = -a[i];
      end
      OP_SCALE:  for (int i = 0; i < 4; i++) r[i] = qmul(a[i], s);
      OP_NORMSQ: r[0] = longint'(sumsq >> FRAC);
      OP_NORM:   r[0] = longint'(root64(sumsq));
      OP_RECIP: begin
        ns = longint'(sumsq >> FRAC);
        if (ns == 0) begin
          div0 = 1'b1;
        end else begin
          r[0] = (a[0] * (64'sd1 <<< FRAC)) / ns;
          for (int i = 1; i < 4; i++) r[i] = (-a[i] * (64'sd1 <<< FRAC)) / ns;
        end
      end
      OP_PURITY: begin
        mag = (a[0] < 0) ? -a[0] : a[0];
        o.scalar_nonzero = (mag > longint'(tol));
      end
      default: ;
    endcase
    for (int i = 0; i < 4; i++) begin
      if (r[i] > 64'sd2147483647) begin
        r[i] = 64'sd2147483647;
        ovf = 1'b1;
      end else if (r[i] < -64'sd2147483648) begin
        r[i] = -64'sd2147483648;
        ovf = 1'b1;
      end
    end
    o.r_w = r[0][31:0];
    o.r_x = r[1][31:0];
    o.r_y = r[2][31:0];
    o.r_z = r[3][31:0];
    o.error_code = div0 ? ERR_DIV0 : (ovf ? ERR_OVF : ERR_OK);
    return o;
  endfunction

  function automatic qau_in_t quat_pair(logic [3:0] op, logic [31:0] aw, logic [31:0] ax,
                                        logic [31:0] ay, logic [31:0] az, logic [31:0] bw,
                                        logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                                        logic [31:0] sf);
    qau_in_t q;
    q = '{op, aw, ax, ay, az, bw, bx, by, bz, sf};
    return q;
  endfunction

  function automatic qau_out_t quat_out(logic [31:0] w, logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z, logic nz, logic [1:0] err);
    qau_out_t o;
    o = '{w, x, y, z, nz, err};
    return o;
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
      5, 6:          return $urandom;
      7: begin
        case ($urandom_range(0, 3))
          0: return QMIN;
          1: return QMAX;
          2: return 32'hffff_ffff;
          default: return 32'd0;
        endcase
      end
      default:       return 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
    endcase
  endfunction

  function automatic qau_in_t rand_pair();
    logic [3:0] op;
    op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                      : 4'($urandom_range(0, 9));
    return quat_pair(op, rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                     rand_coef(), rand_coef(), rand_coef(), rand_coef());
  endfunction

  task automatic add_row(qau_in_t q, bit typed, qau_out_t e);
    dir_in.push_back(q);
    dir_typed.push_back(typed);
    dir_exp.push_back(e);
  endtask

  task automatic send_pair(qau_in_t q, bit typed, qau_out_t e, int gap);
    start <= 1'b1;
    operands <= q;
    do @(posedge clk); while (busy);
    pending_q.push_back(typed ? e : quat_result(q, tolerance));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_ZERO_TOL;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tolerance = v[30:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int idle_gap(bit calm);
    if (calm || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 12);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    qau_out_t want;
    if (!rst && result_valid) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else begin
        want = pending_q.pop_front();
        if (result.r_w !== want.r_w || result.r_x !== want.r_x ||
            result.r_y !== want.r_y || result.r_z !== want.r_z ||
            result.scalar_nonzero !== want.scalar_nonzero ||
            result.error_code !== want.error_code) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %h, got %h", want, result);
        end
      end
    end
  end

  initial begin
    logic [31:0] tol_set[6];
    qau_out_t    none;
    int          per_phase;
    rst = 1'b1;
    start = 1'b0;
    operands = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tolerance = ZERO_TOL_RESET;
    mismatches = 0;
    cycles = 0;
    none = '0;

    add_row(quat_pair(OP_PURITY, 32'd66, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            quat_out(0, 0, 0, 0, 1'b0, ERR_OK));
    add_row(quat_pair(OP_PURITY, -32'sd67, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            quat_out(0, 0, 0, 0, 1'b1, ERR_OK));
    add_row(quat_pair(OP_RECIP, 0, 0, 0, 0, 5, 5, 5, 5, 5), 1,
            quat_out(0, 0, 0, 0, 1'b0, ERR_DIV0));
    add_row(quat_pair(OP_RECIP, 32'd255, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            quat_out(0, 0, 0, 0, 1'b0, ERR_DIV0));
    add_row(quat_pair(OP_CONJ, 32'd7, QMIN, 32'd1, 0, 0, 0, 0, 0, 0), 1,
            quat_out(32'd7, QMAX, 32'hffff_ffff, 0, 1'b0, ERR_OVF));
    add_row(quat_pair(OP_ADD, QMAX, QMIN, 32'd1, 0, 32'd1, QMIN, 32'd2, 0, 0), 1,
            quat_out(QMAX, QMIN, 32'd3, 0, 1'b0, ERR_OVF));
    add_row(quat_pair(OP_SUB, QMIN, QMAX, 0, 0, 32'd1, QMIN, 0, 0, 0), 1,
            quat_out(QMIN, QMAX, 0, 0, 1'b0, ERR_OVF));
    add_row(quat_pair(4'd10, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX), 1,
            quat_out(0, 0, 0, 0, 1'b0, ERR_OK));
    add_row(quat_pair(4'd15, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN), 1,
            quat_out(0, 0, 0, 0, 1'b0, ERR_OK));
    add_row(quat_pair(OP_MUL, 32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, 32'h0000_8000,
                      32'h0000_4000, 32'hffff_0000, 32'h0003_0000, 32'h0001_8000, 0), 0, none);
    add_row(quat_pair(OP_MUL, QMAX, QMIN, QMAX, QMIN, QMIN, QMAX, QMIN, QMAX, 0), 0, none);
    add_row(quat_pair(OP_PURE, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hffff_ffff,
                      32'hfffe_0000, 32'h0000_0001, 32'h0005_0000, 32'h0007_0000, 0), 0, none);
    add_row(quat_pair(OP_PURE, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, 0), 0, none);
    add_row(quat_pair(OP_SCALE, 32'h0001_0000, 32'hffff_ffff, QMAX, QMIN, 0, 0, 0, 0,
                      32'h0002_0000), 0, none);
    add_row(quat_pair(OP_SCALE, 32'd3, 32'hffff_fffd, 0, 32'd1, 0, 0, 0, 0, 32'hffff_ffff),
            0, none);
    add_row(quat_pair(OP_NORMSQ, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(quat_pair(OP_NORMSQ, QMIN, QMIN, QMIN, QMIN, 0, 0, 0, 0, 0), 0, none);
    add_row(quat_pair(OP_NORM, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(quat_pair(OP_NORM, QMIN, QMIN, QMIN, QMIN, 0, 0, 0, 0, 0), 0, none);
    add_row(quat_pair(OP_NORM, QMAX, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(quat_pair(OP_RECIP, 32'h0002_0000, 32'h0001_0000, 32'hffff_0000, 0, 0, 0, 0, 0, 0),
            0, none);
    add_row(quat_pair(OP_RECIP, QMIN, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(quat_pair(OP_RECIP, 32'd256, 32'hffff_ff00, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(quat_pair(OP_CONJ, QMIN, QMAX, 0, 32'hffff_ffff, 0, 0, 0, 0, 0), 0, none);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_in[i]) send_pair(dir_in[i], dir_typed[i], dir_exp[i], idle_gap(0));
    start <= 1'b0;
    drain();

    tol_set = '{32'd0, QMAX, 32'hffff_ffff, 32'h0001_0000, 32'd66, 32'd0};
    tol_set[5] = $urandom;
    per_phase = 325;
    foreach (tol_set[p]) begin
      write_tolerance(tol_set[p]);
      send_pair(quat_pair(OP_PURITY, tol_set[p] & QMAX, 0, 0, 0, 0, 0, 0, 0, 0), 0, none, 0);
      send_pair(quat_pair(OP_PURITY, (tol_set[p] & QMAX) + 1, 0, 0, 0, 0, 0, 0, 0, 0),
                0, none, 0);
      for (int n = 0; n < per_phase; n++) begin
        if (p == 2 && n == 150) begin
          start <= 1'b0;
          while (pending_q.size() != 0) @(posedge clk);
        end
        send_pair(rand_pair(), 0, none, idle_gap(p == 5 && n > 100));
      end
      start <= 1'b0;
      drain();
    end

    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
